// File: rtl/ipla_pkg.sv
`timescale 1ns / 1ps

package ipla_pkg;

    // Offsets within the /24 pool.
    localparam logic [7:0]  GATEWAY_OFFSET = 8'd1;
    localparam logic [8:0]  LAST_OFFSET    = 9'd254;

    // Reset value of the subnet base, 10.0.0.0 in host order.
    localparam logic [31:0] BASE_RESET = 32'h0A00_0000;

    // Request codes.
    localparam logic REQ_ALLOCATE = 1'b0;
    localparam logic REQ_RELEASE  = 1'b1;

    // Register word indexes on the configuration port.
    localparam logic REG_POOL_BASE = 1'b0;

    // Input beat.
    typedef struct packed {
        logic        req_type;
        logic [31:0] release_ip;
    } t_in_beat;

    // Output beat.
    typedef struct packed {
        logic        granted;
        logic [31:0] lease_ip;
    } t_out_beat;

    // One table entry as stored in the lease memory.
    typedef struct packed {
        logic       in_use;
        logic [7:0] offset;
    } t_entry;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_EMIT
    } t_state;

endpackage

// File: rtl/ip_lease_pool_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_beat  (req_type, release_ip)
// out       output     o_out_valid / i_out_stall o_out_beat (granted, lease_ip)
// cfg       input      psel/penable/pwrite      paddr, pwdata -> prdata, pready
//
// Each item is accepted, then the lease memory is walked one entry per cycle
// through its single read port; an allocate may then append a new lease,
// and its result is loaded into the output register.
// A release walks every entry; an allocate stops at the first free entry.
// Reset clears the entry count and sets the highest offset to the gateway offset; the memory is not cleared.
// A stalled output holds its beat while the next request is already accepted.
module ip_lease_pool_allocator
    import ipla_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_beat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Lease memory and its registered read data.
    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd_data;

    // Control and payload registers.
    t_state              r_state, n_state;
    logic [31:0]         r_base;
    t_in_beat            r_req;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [7:0]          r_highest, n_highest;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    t_out_beat           r_res, n_res;
    logic                r_out_valid;
    t_out_beat           r_out_beat;

    // Memory port controls.
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;

    // Scan and append decisions.
    logic                in_acc;
    logic [31:0]         entry_ip;
    logic                hit_rel;
    logic                hit_alloc;
    logic                issue;
    logic [8:0]          next_off;
    logic                grant_tail;
    logic                emit_go;
    logic                cfg_wr;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign entry_ip  = r_base + {24'd0, r_rd_data.offset};
    assign hit_rel   = (r_state == S_SCAN) && r_pend && (r_req.req_type == REQ_RELEASE)
                       && (entry_ip == r_req.release_ip);
    assign hit_alloc = (r_state == S_SCAN) && r_pend && (r_req.req_type == REQ_ALLOCATE)
                       && !r_rd_data.in_use;
    assign issue     = (r_idx < r_count) && !hit_alloc;

    assign next_off   = {1'b0, r_highest} + 9'd1;
    assign grant_tail = (next_off <= LAST_OFFSET) && (r_count < CNT_W'(TABLE_DEPTH));
    assign emit_go    = !r_out_valid || !i_out_stall;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_BASE);
    assign prdata = (paddr[2] == REG_POOL_BASE) ? r_base : 32'd0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit_alloc) begin
                    n_state = S_EMIT;
                end else if (!issue) begin
                    n_state = (r_req.req_type == REQ_RELEASE) ? S_IDLE : S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_count    = r_count;
        n_highest  = r_highest;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_res      = r_res;
        rd_en      = 1'b0;
        rd_addr    = r_idx[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_pend_idx;
        wr_data    = r_rd_data;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
            end
            S_SCAN: begin
                // Evaluate the entry read last cycle.
                if (hit_rel) begin
                    wr_en          = 1'b1;
                    wr_data.in_use = 1'b0;
                end
                if (hit_alloc) begin
                    wr_en          = 1'b1;
                    wr_data.in_use = 1'b1;
                    n_res.granted  = 1'b1;
                    n_res.lease_ip = entry_ip;
                end
                // Read the next entry in table order.
                if (issue) begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    n_idx      = r_idx + CNT_W'(1);
                end
            end
            S_TAIL: begin
                // No free entry: append the next offset if room remains.
                if (grant_tail) begin
                    wr_en          = 1'b1;
                    wr_addr        = r_count[IDX_W-1:0];
                    wr_data.in_use = 1'b1;
                    wr_data.offset = next_off[7:0];
                    n_count        = r_count + CNT_W'(1);
                    n_highest      = next_off[7:0];
                    n_res.granted  = 1'b1;
                    n_res.lease_ip = r_base + {23'd0, next_off};
                end else begin
                    n_res.granted  = 1'b0;
                    n_res.lease_ip = 32'd0;
                end
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Lease memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_RESET;
            r_count     <= '0;
            r_highest   <= GATEWAY_OFFSET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_highest <= n_highest;
            r_pend    <= n_pend;
            if (cfg_wr) begin
                r_base <= pwdata;
            end
            if (r_state == S_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        if (in_acc) begin
            r_req <= i_in_beat;
        end
        if (r_state == S_EMIT && emit_go) begin
            r_out_beat <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import ipla_pkg::*;
();

    localparam int TABLE_DEPTH = 256;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_POOL_BASE = {REG_POOL_BASE, 2'b00};
    localparam logic [2:0] ADDR_UNLISTED  = 3'b100;

    // A release walks the whole table, so let that much time pass before a write.
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int QUIET_LIMIT  = 8 * (TABLE_DEPTH + 40);
    localparam int MAX_REPORTS  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_beat    in_beat;
    logic        out_valid;
    logic        out_stall;
    t_out_beat   out_beat;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Lease table as the block should hold it.
    logic [31:0] pool_base;
    logic [7:0]  tbl_offset [TABLE_DEPTH];
    logic        tbl_used [TABLE_DEPTH];
    int unsigned tbl_count;
    logic [7:0]  top_offset;

    t_out_beat   lease_expect_q[$];

    bit          idling_on = 1'b0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_alloc = 0;
    int unsigned n_release = 0;
    int unsigned n_reuse = 0;
    int unsigned n_full = 0;
    int unsigned n_zero_ip = 0;
    int unsigned n_cfg = 0;

    ip_lease_pool_allocator #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic void reset_lease_table();
        pool_base  = BASE_RESET;
        tbl_count  = 0;
        top_offset = GATEWAY_OFFSET;
        for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
            tbl_offset[i] = '0;
            tbl_used[i]   = 1'b0;
        end
    endfunction

    // Apply one accepted request to the table and queue the lease it yields.
    function automatic void predict_lease(input t_in_beat beat);
        t_out_beat  res;
        logic [8:0] next_off;
        bit         found;
        found = 1'b0;
        res   = '0;
        if (beat.req_type == REQ_RELEASE) begin
            n_release++;
            for (int unsigned i = 0; i < tbl_count; i++) begin
                if (pool_base + {24'd0, tbl_offset[i]} == beat.release_ip) begin
                    tbl_used[i] = 1'b0;
                end
            end
        end else begin
            n_alloc++;
            // The first free entry in table order is reused.
            for (int unsigned i = 0; i < tbl_count; i++) begin
                if (!found && !tbl_used[i]) begin
                    tbl_used[i]  = 1'b1;
                    res.granted  = 1'b1;
                    res.lease_ip = pool_base + {24'd0, tbl_offset[i]};
                    found        = 1'b1;
                    n_reuse++;
                end
            end
            // Otherwise append the next offset, unless offsets or the table run out.
            if (!found) begin
                next_off = {1'b0, top_offset} + 9'd1;
                if (next_off <= LAST_OFFSET && tbl_count < TABLE_DEPTH) begin
                    tbl_offset[tbl_count] = next_off[7:0];
                    tbl_used[tbl_count]   = 1'b1;
                    tbl_count++;
                    top_offset   = next_off[7:0];
                    res.granted  = 1'b1;
                    res.lease_ip = pool_base + {24'd0, next_off[7:0]};
                end else begin
                    n_full++;
                end
            end
            if (res.granted && res.lease_ip == '0) begin
                n_zero_ip++;
            end
            lease_expect_q.push_back(res);
        end
    endfunction

    // Address of a random entry still in use, or a random address if none is.
    function automatic logic [31:0] leased_ip_pick();
        int unsigned held[$];
        for (int unsigned i = 0; i < tbl_count; i++) begin
            if (tbl_used[i]) begin
                held.push_back(i);
            end
        end
        if (held.size() == 0) begin
            return 32'($urandom());
        end
        return pool_base + {24'd0, tbl_offset[held[$urandom_range(0, held.size() - 1)]]};
    endfunction

    // Send one request beat; returns at the falling edge after it is accepted.
    task automatic send_request(input logic req, input logic [31:0] ip);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap      = $urandom_range(1, 16);
            in_valid = 1'b0;
            in_beat  = {1'($urandom_range(0, 1)), 32'($urandom())};
            repeat (gap) @(negedge i_clk);
        end
        in_beat.req_type   = req;
        in_beat.release_ip = ip;
        in_valid           = 1'b1;
        do @(posedge i_clk); while (in_stall);
        predict_lease(in_beat);
        @(negedge i_clk);
    endtask

    // Mostly allocations and releases of live leases, some releases that miss.
    task automatic random_request(input int unsigned alloc_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            send_request(REQ_ALLOCATE, 32'($urandom()));
        end else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
            send_request(REQ_RELEASE, leased_ip_pick());
        end else if ($urandom_range(0, 1) == 0) begin
            send_request(REQ_RELEASE, 32'($urandom()));
        end else begin
            send_request(REQ_RELEASE, pool_base + 32'($urandom_range(0, 255)));
        end
    endtask

    // Wait until every lease has come back and a release scan has surely ended.
    task automatic drain_pipeline();
        in_valid = 1'b0;
        while (lease_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic check_base_readback();
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = ADDR_POOL_BASE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== pool_base) begin
            report_mismatch($sformatf("pool base reads %h, expected %h", prdata, pool_base));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Register write while the block is idle, followed by a read back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        drain_pipeline();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_POOL_BASE) begin
            pool_base = value;
        end
        n_cfg++;
        @(negedge i_clk);
        check_base_readback();
    endtask

    // Reset value of the base, a release on an empty table, first leases.
    task automatic test_reset_state();
        check_base_readback();
        send_request(REQ_RELEASE, pool_base + 32'd2);
        send_request(REQ_ALLOCATE, 32'hFFFF_FFFF);
        send_request(REQ_ALLOCATE, 32'h0000_0000);
        send_request(REQ_ALLOCATE, 32'($urandom()));
    endtask

    // Freed entries are reused in table order; unknown addresses change nothing.
    task automatic test_release_reuse();
        send_request(REQ_RELEASE, pool_base + 32'd3);
        send_request(REQ_RELEASE, 32'hFFFF_FFFF);
        send_request(REQ_RELEASE, 32'h0000_0000);
        send_request(REQ_ALLOCATE, 32'($urandom()));
        send_request(REQ_RELEASE, pool_base + 32'd4);
        send_request(REQ_RELEASE, pool_base + 32'd2);
        send_request(REQ_ALLOCATE, 32'($urandom()));
        send_request(REQ_ALLOCATE, 32'($urandom()));
        send_request(REQ_ALLOCATE, 32'($urandom()));
    endtask

    // Addresses follow the current base, including one that wraps to zero.
    task automatic test_base_change();
        logic [31:0] old_ip;
        old_ip = pool_base + 32'd3;
        write_register(ADDR_UNLISTED, 32'hDEAD_BEEF);
        write_register(ADDR_POOL_BASE, 32'hC0A8_0100);
        send_request(REQ_RELEASE, old_ip);
        send_request(REQ_RELEASE, pool_base + 32'd3);
        send_request(REQ_ALLOCATE, 32'($urandom()));
        write_register(ADDR_POOL_BASE, 32'h0000_0000);
        send_request(REQ_ALLOCATE, 32'($urandom()));
        write_register(ADDR_POOL_BASE, 32'hFFFF_FFFF);
        send_request(REQ_ALLOCATE, 32'($urandom()));
        write_register(ADDR_POOL_BASE, -(32'(top_offset) + 32'd1));
        send_request(REQ_ALLOCATE, 32'($urandom()));
        send_request(REQ_RELEASE, 32'h0000_0000);
        send_request(REQ_ALLOCATE, 32'($urandom()));
    endtask

    // Allocation-heavy traffic that runs the pool out of offsets.
    task automatic test_fill_pool();
        write_register(ADDR_POOL_BASE, 32'($urandom()));
        idling_on = 1'b1;
        repeat (400) random_request(85);
    endtask

    // Balanced traffic on a full pool, under the reset base and a wrapping one.
    task automatic test_churn();
        write_register(ADDR_POOL_BASE, BASE_RESET);
        repeat (175) random_request(60);
        write_register(ADDR_POOL_BASE, 32'hFFFF_FF80);
        repeat (175) random_request(60);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_steady_stream();
        write_register(ADDR_POOL_BASE, 32'($urandom()));
        idling_on = 1'b0;
        repeat (250) random_request(55);
    endtask

    // Receiver stalls in random bursts while idling is enabled.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    // Compare each accepted result beat against the oldest expected lease.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (lease_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat: granted %0b lease_ip %h",
                                          out_beat.granted, out_beat.lease_ip));
            end else begin
                want = lease_expect_q.pop_front();
                if (out_beat.granted !== want.granted) begin
                    report_mismatch($sformatf("granted %0b, expected %0b",
                                              out_beat.granted, want.granted));
                end
                if (out_beat.lease_ip !== want.lease_ip) begin
                    report_mismatch($sformatf("lease_ip %h, expected %h",
                                              out_beat.lease_ip, want.lease_ip));
                end
            end
        end
    end

    // Watchdog: too long without any beat or register access means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ip_lease_pool_allocator verification failed");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        in_valid = 1'b0;
        in_beat  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;
        reset_lease_table();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_release_reuse();
        test_base_change();
        test_fill_pool();
        test_churn();
        test_steady_stream();
        drain_pipeline();

        $display("Ran %0d allocations (%0d reused, %0d refused as full, %0d at address 0)",
                 n_alloc, n_reuse, n_full, n_zero_ip);
        $display("and %0d releases over %0d register writes; %0d mismatches.",
                 n_release, n_cfg, error_count);
        if (error_count == 0) begin
            $display("ip_lease_pool_allocator verification clean");
        end else begin
            $display("ip_lease_pool_allocator verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ipla_pkg.sv
rtl/ip_lease_pool_allocator.sv
verif/tb_top.sv
